// ===== rtl/core/gmc_pkg.sv =====
// gmc_pkg: shared types and codes for the gate motion controller
// event codes, gate states, owners, and the word structs passed between stages
// no dependencies
package gmc_pkg;

	localparam int unsigned CMD_W   = 3;
	localparam int unsigned BTN_W   = 2;
	localparam int unsigned HOLD_W  = 16;
	localparam int unsigned STATE_W = 3;
	localparam int unsigned OWNER_W = 2;

	localparam logic [HOLD_W-1:0] HOLD_THR_RESET = 16'd500;

	typedef enum logic [CMD_W-1:0] {
		CMD_PRESS        = 3'd0,
		CMD_RELEASE      = 3'd1,
		CMD_OPEN_LIMIT   = 3'd2,
		CMD_CLOSED_LIMIT = 3'd3,
		CMD_CONFLICT     = 3'd4
	} cmd_t;

	typedef enum logic [STATE_W-1:0] {
		ST_IDLE_CLOSED = 3'd0,
		ST_OPENING     = 3'd1,
		ST_IDLE_OPEN   = 3'd2,
		ST_CLOSING     = 3'd3,
		ST_STOPPED     = 3'd4
	} gate_state_t;

	typedef enum logic [OWNER_W-1:0] {
		OWN_NONE     = 2'd0,
		OWN_DRIVER   = 2'd1,
		OWN_SECURITY = 2'd2
	} owner_t;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [BTN_W-1:0]  button;
		logic [HOLD_W-1:0] hold_ms;
	} gmc_item_t;

	typedef struct packed {
		logic [STATE_W-1:0] gate_state;
		logic [OWNER_W-1:0] gate_owner;
		logic               auto_mode;
	} gmc_status_t;

endpackage

// ===== rtl/core/gate_motion_controller_unit.sv =====
// gate_motion_controller_unit: top level of the gate motion controller
// input register, next-state logic with state registers, result register
// depends on gmc_pkg, gmc_in_stage, gmc_fsm, gmc_out_stage
//
//   channel   signals                            word
//   in        in_valid / in_ready                command, button, hold_ms
//   out       out_valid / out_ready              gate_state, gate_owner, auto_mode
//   cfg       cfg_we / cfg_wdata                 hold threshold in ms
//
// one event per cycle sustained while out_ready stays high; an accepted event passes the input
// register and then the result register before the result is valid and can be taken
// the state registers update as an event leaves the input register into the result register
// a waiting result with out_ready low holds the result register; the input register
// takes one more word, then in_ready falls until the result is taken
// reset: gate idle closed, no owner, auto mode, no buttons held, threshold 500 ms
module gate_motion_controller_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [gmc_pkg::CMD_W-1:0]   command,
	input  logic [gmc_pkg::BTN_W-1:0]   button,
	input  logic [gmc_pkg::HOLD_W-1:0]  hold_ms,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [gmc_pkg::STATE_W-1:0] gate_state,
	output logic [gmc_pkg::OWNER_W-1:0] gate_owner,
	output logic                        auto_mode,
	input  logic                        cfg_we,
	input  logic [gmc_pkg::HOLD_W-1:0]  cfg_wdata
);
	import gmc_pkg::*;

	gmc_item_t          in_item;
	gmc_item_t          item_s1;
	logic               valid_s1;
	logic               advance;
	gmc_status_t        nxt_status;
	gmc_status_t        status_s2;
	logic [HOLD_W-1:0]  hold_thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_thr_q <= HOLD_THR_RESET;
		end else if (cfg_we) begin
			hold_thr_q <= cfg_wdata;
		end
	end

	assign in_item.command = command;
	assign in_item.button  = button;
	assign in_item.hold_ms = hold_ms;

	gmc_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	gmc_fsm u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.item_s1    (item_s1),
		.hold_thr   (hold_thr_q),
		.nxt_status (nxt_status)
	);

	gmc_out_stage u_out_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.advance    (advance),
		.nxt_status (nxt_status),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status_s2  (status_s2)
	);

	assign gate_state = status_s2.gate_state;
	assign gate_owner = status_s2.gate_owner;
	assign auto_mode  = status_s2.auto_mode;

endmodule

// ===== rtl/core/gmc_in_stage.sv =====
// gmc_in_stage: input register for one event word with valid/ready handshake
// depends on gmc_pkg
module gmc_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  gmc_pkg::gmc_item_t in_item,
	input  logic               advance,
	output logic               valid_s1,
	output gmc_pkg::gmc_item_t item_s1
);
	import gmc_pkg::*;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== rtl/core/gmc_fsm.sv =====
// gmc_fsm: gate state, owner, mode and held-button registers with next-state logic
// updates once per event word leaving the input register
// depends on gmc_pkg
module gmc_fsm (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  gmc_pkg::gmc_item_t          item_s1,
	input  logic [gmc_pkg::HOLD_W-1:0]  hold_thr,
	output gmc_pkg::gmc_status_t        nxt_status
);
	import gmc_pkg::*;

	logic [STATE_W-1:0] state_q, state_d;
	logic [OWNER_W-1:0] owner_q, owner_d;
	logic               auto_q, auto_d;
	logic [1:0]         open_held_q, open_held_d;
	logic [1:0]         close_held_q, close_held_d;
	logic               panel;
	logic               is_open;
	logic [OWNER_W-1:0] who;
	logic               moving;
	logic               both_held;
	logic               drv_blocked;
	logic               dir_match;

	always_comb begin
		panel        = item_s1.button[1];
		is_open      = !item_s1.button[0];
		who          = item_s1.button[1] ? OWN_SECURITY : OWN_DRIVER;
		moving       = (state_q == ST_OPENING) || (state_q == ST_CLOSING);
		state_d      = state_q;
		owner_d      = owner_q;
		auto_d       = auto_q;
		open_held_d  = open_held_q;
		close_held_d = close_held_q;
		// held flag after this press: the other button of the same panel decides
		both_held    = is_open ? close_held_q[panel] : open_held_q[panel];
		drv_blocked  = (who == OWN_DRIVER) && (owner_q == OWN_SECURITY) && moving;
		dir_match    = (state_q == ST_OPENING) ? is_open : !is_open;

		case (item_s1.command)
			CMD_PRESS: begin
				if (is_open) open_held_d[panel] = 1'b1;
				else close_held_d[panel] = 1'b1;
				if (!both_held && !drv_blocked) begin
					if (is_open) begin
						if (state_q == ST_IDLE_CLOSED || state_q == ST_STOPPED ||
						    state_q == ST_CLOSING) begin
							owner_d = who;
							auto_d  = 1'b0;
							state_d = ST_OPENING;
						end else if (state_q == ST_OPENING && who == OWN_SECURITY &&
						             owner_q == OWN_DRIVER) begin
							owner_d = OWN_SECURITY;
							auto_d  = 1'b0;
						end
					end else begin
						if (state_q == ST_IDLE_OPEN || state_q == ST_STOPPED ||
						    state_q == ST_OPENING) begin
							owner_d = who;
							auto_d  = 1'b0;
							state_d = ST_CLOSING;
						end else if (state_q == ST_CLOSING && who == OWN_SECURITY &&
						             owner_q == OWN_DRIVER) begin
							owner_d = OWN_SECURITY;
							auto_d  = 1'b0;
						end
					end
				end
			end
			CMD_RELEASE: begin
				if (is_open) open_held_d[panel] = 1'b0;
				else close_held_d[panel] = 1'b0;
				if (moving && owner_q == who && dir_match) begin
					if (item_s1.hold_ms < hold_thr) begin
						auto_d = 1'b1;
					end else begin
						owner_d = OWN_NONE;
						state_d = ST_STOPPED;
					end
				end
			end
			CMD_OPEN_LIMIT: begin
				if (state_q == ST_OPENING) begin
					owner_d = OWN_NONE;
					state_d = ST_IDLE_OPEN;
				end
			end
			CMD_CLOSED_LIMIT: begin
				if (state_q == ST_CLOSING) begin
					owner_d = OWN_NONE;
					state_d = ST_IDLE_CLOSED;
				end
			end
			CMD_CONFLICT: begin
				owner_d = OWN_NONE;
				state_d = ST_STOPPED;
			end
			default: begin
			end
		endcase

		nxt_status.gate_state = state_d;
		nxt_status.gate_owner = owner_d;
		nxt_status.auto_mode  = auto_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE_CLOSED;
			owner_q      <= OWN_NONE;
			auto_q       <= 1'b1;
			open_held_q  <= 2'b00;
			close_held_q <= 2'b00;
		end else if (advance) begin
			state_q      <= state_d;
			owner_q      <= owner_d;
			auto_q       <= auto_d;
			open_held_q  <= open_held_d;
			close_held_q <= close_held_d;
		end
	end

endmodule

// ===== rtl/core/gmc_out_stage.sv =====
// gmc_out_stage: result register holding one status word until taken
// depends on gmc_pkg
module gmc_out_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_s1,
	output logic                 advance,
	input  gmc_pkg::gmc_status_t nxt_status,
	output logic                 out_valid,
	input  logic                 out_ready,
	output gmc_pkg::gmc_status_t status_s2
);
	import gmc_pkg::*;

	assign advance = valid_s1 && (!out_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || out_ready) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_s2 <= nxt_status;
		end
	end

endmodule

// ===== rtl/core/gmc_checker.sv =====
// gmc_checker: port-level checks for gate_motion_controller_unit
// bound to the top level below; depends on gmc_pkg
module gmc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [gmc_pkg::STATE_W-1:0] gate_state,
	input logic [gmc_pkg::OWNER_W-1:0] gate_owner,
	input logic                        auto_mode
);
	import gmc_pkg::*;

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(gate_state) &&
		$stable(gate_owner) && $stable(auto_mode))
		else $error("result word changed while stalled");

	// empty result register never blocks input
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	// resting gate has no owner
	a_idle_no_owner: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (gate_state == ST_IDLE_CLOSED || gate_state == ST_IDLE_OPEN ||
		gate_state == ST_STOPPED) |-> gate_owner == OWN_NONE)
		else $error("owner set while gate at rest");

	// moving gate always has an owner
	a_moving_owner: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (gate_state == ST_OPENING || gate_state == ST_CLOSING)
		|-> gate_owner != OWN_NONE)
		else $error("gate moving with no owner");

endmodule

bind gate_motion_controller_unit gmc_checker u_gmc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.gate_state (gate_state),
	.gate_owner (gate_owner),
	.auto_mode  (auto_mode)
);

// ===== tb/gmc_status_checker.sv =====
// gmc_status_checker: watches the event, result and config channels of the gate controller
// predicts each result word from accepted event words and compares field by field
// depends on gmc_pkg
module gmc_status_checker
	import gmc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [CMD_W-1:0]   command,
	input  logic [BTN_W-1:0]   button,
	input  logic [HOLD_W-1:0]  hold_ms,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [STATE_W-1:0] gate_state,
	input  logic [OWNER_W-1:0] gate_owner,
	input  logic               auto_mode,
	input  logic               cfg_we,
	input  logic [HOLD_W-1:0]  cfg_wdata,
	output int                 fail_count,
	output int                 pending_words
);

	gate_state_t       gate_q;
	owner_t            owner_q;
	logic              auto_q;
	logic [1:0]        open_down;
	logic [1:0]        close_down;
	logic [HOLD_W-1:0] threshold_q;
	gmc_status_t       status_q[$];
	gmc_status_t       want;

	task automatic report_mismatch(input string what, input int exp_v, input int got_v);
		$display("mismatch on %s: expected %0d, got %0d at %0t", what, exp_v, got_v, $time);
		fail_count++;
	endtask

	function automatic gmc_status_t advance_gate(input logic [CMD_W-1:0] cmd,
			input logic [BTN_W-1:0] btn, input logic [HOLD_W-1:0] hold);
		owner_t      who;
		logic        panel;
		logic        close_btn;
		logic        moving;
		gmc_status_t res;
		who = btn[1] ? OWN_SECURITY : OWN_DRIVER;
		panel = btn[1];
		close_btn = btn[0];
		moving = (gate_q == ST_OPENING) || (gate_q == ST_CLOSING);
		if (cmd == CMD_PRESS || cmd == CMD_RELEASE) begin
			if (close_btn)
				close_down[panel] = (cmd == CMD_PRESS);
			else
				open_down[panel] = (cmd == CMD_PRESS);
		end
		case (cmd)
			CMD_PRESS: begin
				// both buttons of one panel held, or driver against security motion
				if (!(open_down[panel] && close_down[panel]) &&
						!(who == OWN_DRIVER && owner_q == OWN_SECURITY && moving)) begin
					if (!close_btn) begin
						if (gate_q == ST_IDLE_CLOSED || gate_q == ST_STOPPED ||
								gate_q == ST_CLOSING) begin
							owner_q = who;
							auto_q = 1'b0;
							gate_q = ST_OPENING;
						end else if (gate_q == ST_OPENING && who == OWN_SECURITY &&
								owner_q == OWN_DRIVER) begin
							owner_q = OWN_SECURITY;
							auto_q = 1'b0;
						end
					end else begin
						if (gate_q == ST_IDLE_OPEN || gate_q == ST_STOPPED ||
								gate_q == ST_OPENING) begin
							owner_q = who;
							auto_q = 1'b0;
							gate_q = ST_CLOSING;
						end else if (gate_q == ST_CLOSING && who == OWN_SECURITY &&
								owner_q == OWN_DRIVER) begin
							owner_q = OWN_SECURITY;
							auto_q = 1'b0;
						end
					end
				end
			end
			CMD_RELEASE: begin
				if (moving && owner_q == who && ((gate_q == ST_OPENING) != close_btn)) begin
					if (hold < threshold_q) begin
						auto_q = 1'b1;
					end else begin
						owner_q = OWN_NONE;
						gate_q = ST_STOPPED;
					end
				end
			end
			CMD_OPEN_LIMIT: begin
				if (gate_q == ST_OPENING) begin
					owner_q = OWN_NONE;
					gate_q = ST_IDLE_OPEN;
				end
			end
			CMD_CLOSED_LIMIT: begin
				if (gate_q == ST_CLOSING) begin
					owner_q = OWN_NONE;
					gate_q = ST_IDLE_CLOSED;
				end
			end
			CMD_CONFLICT: begin
				owner_q = OWN_NONE;
				gate_q = ST_STOPPED;
			end
			default: ;
		endcase
		res.gate_state = gate_q;
		res.gate_owner = owner_q;
		res.auto_mode = auto_q;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_q = ST_IDLE_CLOSED;
			owner_q = OWN_NONE;
			auto_q = 1'b1;
			open_down = '0;
			close_down = '0;
			threshold_q = HOLD_THR_RESET;
			status_q.delete();
			fail_count = 0;
			pending_words = 0;
		end else begin
			if (cfg_we)
				threshold_q = cfg_wdata;
			if (out_valid && out_ready) begin
				if (status_q.size() == 0) begin
					report_mismatch("result word with nothing pending", 0, int'(gate_state));
				end else begin
					want = status_q.pop_front();
					if (gate_state !== want.gate_state)
						report_mismatch("gate_state", want.gate_state, gate_state);
					if (gate_owner !== want.gate_owner)
						report_mismatch("gate_owner", want.gate_owner, gate_owner);
					if (auto_mode !== want.auto_mode)
						report_mismatch("auto_mode", want.auto_mode, auto_mode);
				end
			end
			if (in_valid && in_ready)
				status_q.push_back(advance_gate(command, button, hold_ms));
			pending_words = status_q.size();
		end
	end

endmodule

// ===== tb/gate_motion_controller_unit_test.sv =====
// gate_motion_controller_unit_test: stimulus and verdict for the gate motion controller
// directed gate scenarios, then button gestures under several hold thresholds
// depends on gmc_pkg, gate_motion_controller_unit, gmc_status_checker
module gate_motion_controller_unit_test;
	import gmc_pkg::*;

	localparam logic [BTN_W-1:0] BUTTON_DRIVER_OPEN  = 2'd0;
	localparam logic [BTN_W-1:0] BUTTON_DRIVER_CLOSE = 2'd1;
	localparam logic [BTN_W-1:0] BUTTON_GUARD_OPEN   = 2'd2;
	localparam logic [BTN_W-1:0] BUTTON_GUARD_CLOSE  = 2'd3;
	localparam logic [CMD_W-1:0] CMD_SPARE_LO  = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI  = 3'd7;
	localparam logic [HOLD_W-1:0] HOLD_MAX     = 16'hFFFF;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [CMD_W-1:0]   command;
	logic [BTN_W-1:0]   button;
	logic [HOLD_W-1:0]  hold_ms;
	logic               out_valid;
	logic               out_ready;
	logic [STATE_W-1:0] gate_state;
	logic [OWNER_W-1:0] gate_owner;
	logic               auto_mode;
	logic               cfg_we;
	logic [HOLD_W-1:0]  cfg_wdata;
	int                 checker_fails;
	int                 pending_words;

	int words_sent;
	int steady_in;
	int steady_out;
	int no_gap_words;
	int cur_threshold;
	bit long_stall_req;

	gate_motion_controller_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.button     (button),
		.hold_ms    (hold_ms),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.gate_state (gate_state),
		.gate_owner (gate_owner),
		.auto_mode  (auto_mode),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	gmc_status_checker status_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.button        (button),
		.hold_ms       (hold_ms),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.gate_state    (gate_state),
		.gate_owner    (gate_owner),
		.auto_mode     (auto_mode),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.fail_count    (checker_fails),
		.pending_words (pending_words)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (no_gap_words > 0) begin
			no_gap_words--;
			return 0;
		end
		if (steady_in > 0) begin
			steady_in--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3)
			steady_in = $urandom_range(10, 40);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	function automatic logic [HOLD_W-1:0] pick_hold();
		int v;
		case ($urandom_range(0, 6))
			0: v = 0;
			1: v = HOLD_MAX;
			2: v = cur_threshold - 1;
			3: v = cur_threshold;
			4: v = cur_threshold + 1;
			5: v = $urandom_range(0, 2 * cur_threshold + 1);
			default: v = $urandom_range(0, HOLD_MAX);
		endcase
		if (v < 0)
			v = 0;
		if (v > HOLD_MAX)
			v = HOLD_MAX;
		return HOLD_W'(v);
	endfunction

	// call at a falling edge; returns at the falling edge after the word is taken
	task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [BTN_W-1:0] btn,
			input logic [HOLD_W-1:0] hold);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		button <= btn;
		hold_ms <= hold;
		do @(posedge clk); while (!in_ready);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_noise();
		send_word(CMD_W'($urandom_range(0, CMD_SPARE_HI)),
			BTN_W'($urandom_range(BUTTON_DRIVER_OPEN, BUTTON_GUARD_CLOSE)),
			HOLD_W'($urandom_range(0, HOLD_MAX)));
	endtask

	task automatic send_limit(input logic [CMD_W-1:0] cmd);
		send_word(cmd, BTN_W'($urandom_range(BUTTON_DRIVER_OPEN, BUTTON_GUARD_CLOSE)),
			HOLD_W'($urandom_range(0, HOLD_MAX)));
	endtask

	// press, maybe interference, release, then the matching limit in half of the runs
	task automatic run_gesture();
		logic [BTN_W-1:0] btn;
		logic             partner;
		btn = BTN_W'($urandom_range(BUTTON_DRIVER_OPEN, BUTTON_GUARD_CLOSE));
		partner = ($urandom_range(0, 4) == 0);
		if ($urandom_range(0, 3) == 0)
			send_noise();
		send_word(CMD_PRESS, btn, HOLD_W'($urandom_range(0, HOLD_MAX)));
		if (partner)
			send_word(CMD_PRESS, btn ^ BUTTON_DRIVER_CLOSE, HOLD_W'($urandom_range(0, HOLD_MAX)));
		if ($urandom_range(0, 2) == 0)
			send_noise();
		send_word(CMD_RELEASE, btn, pick_hold());
		if (partner)
			send_word(CMD_RELEASE, btn ^ BUTTON_DRIVER_CLOSE, pick_hold());
		case ($urandom_range(0, 7))
			0, 1, 2, 3: send_limit(btn[0] ? CMD_CLOSED_LIMIT : CMD_OPEN_LIMIT);
			4: send_limit(CMD_CONFLICT);
			5: send_limit(btn[0] ? CMD_OPEN_LIMIT : CMD_CLOSED_LIMIT);
			default: ;
		endcase
	endtask

	task automatic run_gestures(input int n_words);
		int target;
		target = words_sent + n_words;
		while (words_sent < target)
			run_gesture();
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_words != 0)
			@(negedge clk);
	endtask

	task automatic write_threshold(input logic [HOLD_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_threshold = value;
	endtask

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_stall_req) begin
				out_ready <= 1'b0;
				repeat (80) @(negedge clk);
				long_stall_req = 1'b0;
			end else if (steady_out > 0) begin
				steady_out--;
				out_ready <= 1'b1;
			end else begin
				case ($urandom_range(0, 99)) inside
					[0:2]: begin
						steady_out = $urandom_range(10, 40);
						out_ready <= 1'b1;
					end
					[3:69]: out_ready <= 1'b1;
					[70:94]: begin
						out_ready <= 1'b0;
						repeat ($urandom_range(0, 2)) @(negedge clk);
					end
					default: begin
						out_ready <= 1'b0;
						repeat ($urandom_range(5, 25)) @(negedge clk);
					end
				endcase
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = '0;
		button = '0;
		hold_ms = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		words_sent = 0;
		steady_in = 0;
		steady_out = 0;
		no_gap_words = 0;
		long_stall_req = 1'b0;
		cur_threshold = HOLD_THR_RESET;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, reset threshold
		send_word(CMD_SPARE_LO, BUTTON_GUARD_CLOSE, HOLD_MAX);
		send_limit(CMD_OPEN_LIMIT);
		send_limit(CMD_CLOSED_LIMIT);
		send_word(CMD_PRESS, BUTTON_DRIVER_OPEN, 16'd0);
		send_limit(CMD_CLOSED_LIMIT);
		send_word(CMD_RELEASE, BUTTON_DRIVER_OPEN, 16'd0);
		send_word(CMD_PRESS, BUTTON_GUARD_OPEN, HOLD_MAX);
		send_word(CMD_PRESS, BUTTON_DRIVER_CLOSE, 16'd0);
		send_word(CMD_RELEASE, BUTTON_DRIVER_CLOSE, HOLD_MAX);
		send_word(CMD_RELEASE, BUTTON_GUARD_OPEN, HOLD_THR_RESET - 16'd1);
		send_limit(CMD_OPEN_LIMIT);
		send_word(CMD_PRESS, BUTTON_GUARD_CLOSE, 16'd0);
		send_word(CMD_PRESS, BUTTON_GUARD_OPEN, 16'd0);
		send_word(CMD_RELEASE, BUTTON_GUARD_OPEN, 16'd0);
		send_word(CMD_RELEASE, BUTTON_GUARD_CLOSE, HOLD_THR_RESET);
		send_word(CMD_PRESS, BUTTON_DRIVER_CLOSE, 16'd0);
		send_word(CMD_PRESS, BUTTON_GUARD_CLOSE, 16'd0);
		send_word(CMD_PRESS, BUTTON_DRIVER_OPEN, 16'd0);
		send_limit(CMD_CONFLICT);
		send_word(CMD_RELEASE, BUTTON_DRIVER_OPEN, HOLD_MAX);
		send_word(CMD_PRESS, BUTTON_GUARD_OPEN, 16'd0);
		send_word(CMD_PRESS, BUTTON_DRIVER_CLOSE, 16'd0);
		send_word(CMD_RELEASE, BUTTON_GUARD_OPEN, HOLD_MAX);
		send_limit(CMD_CONFLICT);
		send_word(CMD_SPARE_HI, BUTTON_DRIVER_OPEN, 16'd0);
		drain_results();

		// every matching release stops the gate
		write_threshold(16'd0);
		run_gestures(100);
		drain_results();

		// matching releases are taps unless held for HOLD_MAX ms; receiver holds off while words keep coming
		write_threshold(HOLD_MAX);
		long_stall_req = 1'b1;
		no_gap_words = 40;
		run_gestures(120);
		drain_results();

		write_threshold(HOLD_W'($urandom_range(1, HOLD_MAX - 1)));
		run_gestures(60);
		drain_results();
		run_gestures(60);
		drain_results();

		write_threshold(HOLD_W'($urandom_range(1, 1000)));
		run_gestures(160);
		drain_results();

		repeat (8) @(negedge clk);
		if (checker_fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/gmc_pkg.sv
rtl/core/gmc_in_stage.sv
rtl/core/gmc_fsm.sv
rtl/core/gmc_out_stage.sv
rtl/core/gate_motion_controller_unit.sv
rtl/core/gmc_checker.sv
tb/gmc_status_checker.sv
tb/gate_motion_controller_unit_test.sv
